/* src/gpio_pkg.sv */
// ---------------------------------------------------------------------------
// gpio_pkg
// shared types, word map and codes of the gpio register block
// ---------------------------------------------------------------------------
package gpio_pkg;

  // pins that really exist, and the width of every pin vector field
  localparam int PinCount = 54;
  localparam int PinW     = 54;

  localparam int AddrW = 6;
  localparam int DataW = 32;

  // function select layout
  localparam int FselBits    = 3;
  localparam int PinsPerWord = 10;
  localparam int FselWords   = 6;
  localparam int FselIdxW    = $clog2(FselWords);
  localparam int FselWordW   = FselBits * PinsPerWord;

  // bus access kinds
  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // word map
  localparam logic [AddrW-1:0] AddrFselLast = 6'd5;
  localparam logic [AddrW-1:0] AddrSet0     = 6'd7;
  localparam logic [AddrW-1:0] AddrSet1     = 6'd8;
  localparam logic [AddrW-1:0] AddrClr0     = 6'd10;
  localparam logic [AddrW-1:0] AddrClr1     = 6'd11;
  localparam logic [AddrW-1:0] AddrLev0     = 6'd13;
  localparam logic [AddrW-1:0] AddrLev1     = 6'd14;
  localparam logic [AddrW-1:0] AddrPullMode = 6'd37;
  localparam logic [AddrW-1:0] AddrPullClk0 = 6'd38;
  localparam logic [AddrW-1:0] AddrPullClk1 = 6'd39;

  // function and pull codes
  localparam logic [FselBits-1:0] FuncOutput = 3'd1;
  localparam logic [1:0]          PullDown   = 2'd1;
  localparam logic [1:0]          PullUp     = 2'd2;

  typedef struct packed {
    logic             command;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic [PinW-1:0]  pin_levels;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [PinW-1:0]  drive_levels;
    logic [PinW-1:0]  output_enable;
    logic [PinW-1:0]  pull_up;
    logic [PinW-1:0]  pull_down;
  } rsp_t;

  // control from the decoder to the per-pin store
  typedef struct packed {
    logic                fsel_we;
    logic [FselIdxW-1:0] fsel_word;
    logic                pclk_we;
    logic                pclk_hi;
    logic [DataW-1:0]    data;
    logic [1:0]          pull_mode;
  } bank_ctl_t;

  // status from the per-pin store
  typedef struct packed {
    logic [DataW-1:0] fsel_rd;
    logic [PinW-1:0]  oe;
    logic [PinW-1:0]  pu;
    logic [PinW-1:0]  pd;
  } bank_stat_t;

endpackage

/* src/gpio_pin_bank.sv */
// ---------------------------------------------------------------------------
// gpio_pin_bank
// per-pin function codes and latched pull modes, with decoded pin outputs
// ---------------------------------------------------------------------------
module gpio_pin_bank (
  input  logic                  clk,
  input  logic                  rst,
  input  gpio_pkg::bank_ctl_t   ctl,
  output gpio_pkg::bank_stat_t  stat
);

  localparam int PclkWords = 2;

  logic [gpio_pkg::FselBits-1:0]  fsel_codes [gpio_pkg::PinCount];
  logic [1:0]                     pull_modes [gpio_pkg::PinCount];
  logic [gpio_pkg::FselWordW-1:0] word_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < gpio_pkg::PinCount; p++) begin
        fsel_codes[p] <= '0;
        pull_modes[p] <= '0;
      end
    end else begin
      // ten codes per select word, the last word is short
      for (int w = 0; w < gpio_pkg::FselWords; w++) begin
        for (int k = 0; k < gpio_pkg::PinsPerWord &&
                        w * gpio_pkg::PinsPerWord + k < gpio_pkg::PinCount; k++) begin
          if (ctl.fsel_we && ctl.fsel_word == gpio_pkg::FselIdxW'(w)) begin
            fsel_codes[w * gpio_pkg::PinsPerWord + k] <=
              ctl.data[k*gpio_pkg::FselBits +: gpio_pkg::FselBits];
          end
        end
      end
      // pull clock words cover pins 0-31 and 32-53
      for (int h = 0; h < PclkWords; h++) begin
        for (int k = 0; k < gpio_pkg::DataW &&
                        h * gpio_pkg::DataW + k < gpio_pkg::PinCount; k++) begin
          if (ctl.pclk_we && ctl.pclk_hi == 1'(h) && ctl.data[k]) begin
            pull_modes[h * gpio_pkg::DataW + k] <= ctl.pull_mode;
          end
        end
      end
    end
  end

  // pins past the last one read as zero in the top select word
  always_comb begin
    word_sel = '0;
    for (int w = 0; w < gpio_pkg::FselWords; w++) begin
      if (ctl.fsel_word == gpio_pkg::FselIdxW'(w)) begin
        for (int k = 0; k < gpio_pkg::PinsPerWord &&
                        w * gpio_pkg::PinsPerWord + k < gpio_pkg::PinCount; k++) begin
          word_sel[k*gpio_pkg::FselBits +: gpio_pkg::FselBits] =
            fsel_codes[w * gpio_pkg::PinsPerWord + k];
        end
      end
    end
  end

  always_comb begin
    stat.oe = '0;
    stat.pu = '0;
    stat.pd = '0;
    for (int p = 0; p < gpio_pkg::PinCount; p++) begin
      stat.oe[p] = fsel_codes[p] == gpio_pkg::FuncOutput;
      stat.pu[p] = pull_modes[p] == gpio_pkg::PullUp;
      stat.pd[p] = pull_modes[p] == gpio_pkg::PullDown;
    end
    stat.fsel_rd = {{(gpio_pkg::DataW-gpio_pkg::FselWordW){1'b0}}, word_sel};
  end

endmodule

/* src/gpio_register_block.sv */
// ---------------------------------------------------------------------------
// gpio_register_block
// gpio register file: function select, set/clear, level, pull mode/clock
// ---------------------------------------------------------------------------
// One bus access per item. An access is taken at a rising edge with start
// high; busy stays low, so a new access can be issued every cycle and the
// sustained rate is one item per clock. Each access is registered at the
// accepting edge and decoded and applied at the next edge, which also raises
// done: the result shows on rsp with done high for exactly one cycle, and is
// taken at the edge that ends that cycle.
// The receiver cannot stall and must take the
// result in that cycle. The pin fields of rsp (drive_levels, output_enable,
// pull_up, pull_down) show the state after the access; read_data is zero for
// writes and for set, clear, pull clock and unmapped words. All pin state
// resets to zero: pins are inputs, outputs low, pulls off. There is no
// clearing pass.
// ---------------------------------------------------------------------------
module gpio_register_block (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gpio_pkg::req_t  req,
  output logic            done,
  output gpio_pkg::rsp_t  rsp
);

  // input register
  gpio_pkg::req_t req_q;
  logic           req_vld;

  // architectural state outside the pin bank
  logic [gpio_pkg::PinW-1:0]  output_latch;
  logic [gpio_pkg::PinW-1:0]  output_latch_next;
  logic [1:0]                 pull_control;

  // result register
  logic [gpio_pkg::DataW-1:0] read_data;
  logic [gpio_pkg::DataW-1:0] read_data_next;

  gpio_pkg::bank_ctl_t  bank_ctl;
  gpio_pkg::bank_stat_t bank_stat;

  logic is_wr;
  logic is_fsel;
  logic [gpio_pkg::PinW-1:0] pin_present;

  // every access completes in a single pass, so the port never blocks
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  assign is_wr   = req_vld && req_q.command == gpio_pkg::CmdWrite;
  assign is_fsel = req_q.address <= gpio_pkg::AddrFselLast;

  // pins that exist; the rest never latch
  for (genvar p = 0; p < gpio_pkg::PinW; p++) begin : g_mask
    assign pin_present[p] = (p < gpio_pkg::PinCount);
  end

  // control for the per-pin store
  always_comb begin
    bank_ctl.fsel_we   = is_wr && is_fsel;
    bank_ctl.fsel_word = req_q.address[gpio_pkg::FselIdxW-1:0];
    bank_ctl.pclk_we   = is_wr && (req_q.address == gpio_pkg::AddrPullClk0 ||
                                   req_q.address == gpio_pkg::AddrPullClk1);
    bank_ctl.pclk_hi   = req_q.address == gpio_pkg::AddrPullClk1;
    bank_ctl.data      = req_q.write_data;
    bank_ctl.pull_mode = pull_control;
  end

  gpio_pin_bank u_bank (
    .clk  (clk),
    .rst  (rst),
    .ctl  (bank_ctl),
    .stat (bank_stat)
  );

  // set and clear words act on the output latch
  always_comb begin
    logic [63:0] wide_lo;
    logic [63:0] wide_hi;
    wide_lo = {32'b0, req_q.write_data};
    wide_hi = {req_q.write_data, 32'b0};
    output_latch_next = output_latch;
    if (is_wr) begin
      case (req_q.address)
        gpio_pkg::AddrSet0: output_latch_next =
          output_latch | (wide_lo[gpio_pkg::PinW-1:0] & pin_present);
        gpio_pkg::AddrSet1: output_latch_next =
          output_latch | (wide_hi[gpio_pkg::PinW-1:0] & pin_present);
        gpio_pkg::AddrClr0: output_latch_next =
          output_latch & ~(wide_lo[gpio_pkg::PinW-1:0] & pin_present);
        gpio_pkg::AddrClr1: output_latch_next =
          output_latch & ~(wide_hi[gpio_pkg::PinW-1:0] & pin_present);
        default: output_latch_next = output_latch;
      endcase
    end
  end

  // read decode; writes always return zero
  always_comb begin
    logic [63:0] levels;
    levels = {{(64-gpio_pkg::PinW){1'b0}}, req_q.pin_levels & pin_present};
    read_data_next = '0;
    if (req_q.command == gpio_pkg::CmdRead) begin
      if (is_fsel) begin
        read_data_next = bank_stat.fsel_rd;
      end else begin
        case (req_q.address)
          gpio_pkg::AddrLev0:     read_data_next = levels[31:0];
          gpio_pkg::AddrLev1:     read_data_next = levels[63:32];
          gpio_pkg::AddrPullMode: read_data_next = {30'b0, pull_control};
          default:                read_data_next = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_latch <= '0;
      pull_control <= '0;
      done         <= 1'b0;
    end else begin
      output_latch <= output_latch_next;
      if (is_wr && req_q.address == gpio_pkg::AddrPullMode) begin
        pull_control <= req_q.write_data[1:0];
      end
      done <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      read_data <= read_data_next;
    end
  end

  // pin fields come straight off the state, which holds the post-access
  // value for the whole cycle that done is high
  assign rsp.read_data     = read_data;
  assign rsp.drive_levels  = output_latch;
  assign rsp.output_enable = bank_stat.oe;
  assign rsp.pull_up       = bank_stat.pu;
  assign rsp.pull_down     = bank_stat.pd;

endmodule

/* bench/gpio_register_block_tb.sv */
// ---------------------------------------------------------------------------
// gpio_register_block_tb
// self-checking bench for the gpio register block
// ---------------------------------------------------------------------------
// Drives bus accesses through the start/busy command port and keeps its own
// copy of the pin store: function codes, output latch, pull mode and latched
// pull per pin. Every accepted item updates that copy and queues the reply it
// should give. Each done strobe is compared field by field with the oldest
// queued reply. A directed pass hits the word map corners, then random
// traffic runs with several sender idle rates.
// ---------------------------------------------------------------------------
module gpio_register_block_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit     = 200000;
  localparam int ReportLimit    = 10;
  localparam int DrainCycles    = 10;
  localparam int ItemsPerPhase  = 360;

  // words the directed tests aim at beside the named ones
  localparam logic [gpio_pkg::AddrW-1:0] AddrFselWord0 = 6'd0;
  localparam logic [gpio_pkg::AddrW-1:0] AddrFselWord2 = 6'd2;
  localparam logic [gpio_pkg::AddrW-1:0] AddrHole      = 6'd6;
  localparam logic [gpio_pkg::AddrW-1:0] AddrTop       = 6'd63;

  // dut inputs, all known from time zero
  logic            clk   = 1'b0;
  logic            rst   = 1'b1;
  logic            start = 1'b0;
  gpio_pkg::req_t  req   = '0;
  logic            busy;
  logic            done;
  gpio_pkg::rsp_t  rsp;

  gpio_register_block i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the pin store, updated as each item is accepted
  // ---------------------------------------------------------------------------
  logic [gpio_pkg::FselBits-1:0] pin_func [gpio_pkg::PinCount];
  logic [1:0]                    pin_pull [gpio_pkg::PinCount];
  logic [gpio_pkg::PinW-1:0]     out_latch = '0;
  logic [1:0]                    pull_sel  = '0;

  gpio_pkg::rsp_t awaited_replies [$];

  int unsigned cycle_count    = 0;
  int unsigned items_accepted = 0;
  int unsigned reads_accepted = 0;
  int unsigned replies_seen   = 0;
  int unsigned mismatches     = 0;

  initial begin
    for (int p = 0; p < gpio_pkg::PinCount; p++) begin
      pin_func[p] = '0;
      pin_pull[p] = '0;
    end
  end

  // applies one access to the shadow store and returns the reply it causes
  function automatic gpio_pkg::rsp_t apply_access(input gpio_pkg::req_t a);
    gpio_pkg::rsp_t             r;
    logic [gpio_pkg::DataW-1:0] rd;
    logic [63:0]                bits;
    int                         p;
    int                         hi;
    rd = '0;
    r  = '0;
    if (a.address <= gpio_pkg::AddrFselLast) begin
      // ten 3-bit codes per word, pins past the last one do not exist
      for (int k = 0; k < gpio_pkg::PinsPerWord; k++) begin
        p = int'(a.address) * gpio_pkg::PinsPerWord + k;
        if (p < gpio_pkg::PinCount) begin
          if (a.command == gpio_pkg::CmdWrite)
            pin_func[p] = a.write_data[gpio_pkg::FselBits*k +: gpio_pkg::FselBits];
          else
            rd[gpio_pkg::FselBits*k +: gpio_pkg::FselBits] = pin_func[p];
        end
      end
    end else if (a.address == gpio_pkg::AddrSet0 || a.address == gpio_pkg::AddrSet1 ||
                 a.address == gpio_pkg::AddrClr0 || a.address == gpio_pkg::AddrClr1) begin
      if (a.command == gpio_pkg::CmdWrite) begin
        hi   = (a.address == gpio_pkg::AddrSet1 || a.address == gpio_pkg::AddrClr1) ? 32 : 0;
        bits = 64'(a.write_data) << hi;
        if (a.address == gpio_pkg::AddrSet0 || a.address == gpio_pkg::AddrSet1)
          out_latch = out_latch | bits[gpio_pkg::PinW-1:0];
        else
          out_latch = out_latch & ~bits[gpio_pkg::PinW-1:0];
      end
    end else if (a.address == gpio_pkg::AddrLev0 || a.address == gpio_pkg::AddrLev1) begin
      // writes to level words are dropped
      if (a.command == gpio_pkg::CmdRead) begin
        bits = 64'(a.pin_levels);
        rd   = (a.address == gpio_pkg::AddrLev1) ? bits[63:32] : bits[31:0];
      end
    end else if (a.address == gpio_pkg::AddrPullMode) begin
      if (a.command == gpio_pkg::CmdWrite)
        pull_sel = a.write_data[1:0];
      else
        rd = gpio_pkg::DataW'(pull_sel);
    end else if (a.address == gpio_pkg::AddrPullClk0 ||
                 a.address == gpio_pkg::AddrPullClk1) begin
      // latch the current pull mode into every selected pin
      if (a.command == gpio_pkg::CmdWrite) begin
        hi = (a.address == gpio_pkg::AddrPullClk1) ? 32 : 0;
        for (int k = 0; k < gpio_pkg::DataW; k++) begin
          p = hi + k;
          if (p < gpio_pkg::PinCount && a.write_data[k])
            pin_pull[p] = pull_sel;
        end
      end
    end
    // anything else is an unmapped word: nothing stored, reads give zero

    if (a.command == gpio_pkg::CmdWrite)
      rd = '0;

    r.read_data    = rd;
    r.drive_levels = out_latch;
    for (int q = 0; q < gpio_pkg::PinCount; q++) begin
      r.output_enable[q] = (pin_func[q] == gpio_pkg::FuncOutput);
      r.pull_up[q]       = (pin_pull[q] == gpio_pkg::PullUp);
      r.pull_down[q]     = (pin_pull[q] == gpio_pkg::PullDown);
    end
    return r;
  endfunction

  // one field of a reply against its expectation
  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("[%0t] reply %0d %s mismatch: expected %h, got %h",
                 $time, replies_seen, field, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: checks a reply against the replies already awaited, then
  // predicts the item accepted at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    gpio_pkg::rsp_t want;
    if (!rst) begin
      if (done) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("[%0t] reply with nothing awaited: %h", $time, rsp);
        end else begin
          want = awaited_replies.pop_front();
          compare_field("read_data",     64'(want.read_data),     64'(rsp.read_data));
          compare_field("drive_levels",  64'(want.drive_levels),  64'(rsp.drive_levels));
          compare_field("output_enable", 64'(want.output_enable), 64'(rsp.output_enable));
          compare_field("pull_up",       64'(want.pull_up),       64'(rsp.pull_up));
          compare_field("pull_down",     64'(want.pull_down),     64'(rsp.pull_down));
        end
      end
      if (start && !busy) begin
        awaited_replies.push_back(apply_access(req));
        items_accepted++;
        if (req.command == gpio_pkg::CmdRead)
          reads_accepted++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d replies still awaited",
               cycle_count, awaited_replies.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driving helpers
  // ---------------------------------------------------------------------------
  function automatic logic [gpio_pkg::PinW-1:0] random_levels();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[gpio_pkg::PinW-1:0];
  endfunction

  function automatic gpio_pkg::req_t make_access(input logic cmd,
                                                 input logic [gpio_pkg::AddrW-1:0] addr,
                                                 input logic [gpio_pkg::DataW-1:0] data,
                                                 input logic [gpio_pkg::PinW-1:0] levels);
    gpio_pkg::req_t a;
    a.command    = cmd;
    a.address    = addr;
    a.write_data = data;
    a.pin_levels = levels;
    return a;
  endfunction

  // presents one item and holds it until the block takes it; start stays
  // high so back-to-back items need no gap
  task automatic send_access(input gpio_pkg::req_t a);
    @(negedge clk);
    start <= 1'b1;
    req   <= a;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  // a gap with no item, the bus payload wanders meanwhile
  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    req   <= make_access(logic'($urandom_range(1)),
                         gpio_pkg::AddrW'($urandom_range(63)),
                         $urandom(), random_levels());
  endtask

  // sender holds off until every awaited reply is back
  task automatic wait_replies();
    idle_cycle();
    while (awaited_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_word(input logic [gpio_pkg::AddrW-1:0] addr,
                            input logic [gpio_pkg::DataW-1:0] data);
    send_access(make_access(gpio_pkg::CmdWrite, addr, data, random_levels()));
  endtask

  task automatic read_word(input logic [gpio_pkg::AddrW-1:0] addr,
                           input logic [gpio_pkg::PinW-1:0] levels);
    send_access(make_access(gpio_pkg::CmdRead, addr, $urandom(), levels));
  endtask

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------
  // every pin starts as an input with pull off
  task automatic test_reset_state();
    read_word(AddrFselWord0, random_levels());
    read_word(gpio_pkg::AddrPullMode, random_levels());
  endtask

  // select codes, the two unused top bits, the short last word, output code
  task automatic test_function_select();
    write_word(AddrFselWord0, 32'hFFFF_FFFF);
    read_word(AddrFselWord0, random_levels());
    write_word(gpio_pkg::AddrFselLast, 32'h0924_9249);
    read_word(gpio_pkg::AddrFselLast, random_levels());
    write_word(AddrFselWord2, 32'h0924_9249);
    read_word(AddrFselWord2, random_levels());
  endtask

  // set all, including bits past the last pin, then partial clears
  task automatic test_set_clear();
    write_word(gpio_pkg::AddrSet0, 32'hFFFF_FFFF);
    write_word(gpio_pkg::AddrSet1, 32'hFFFF_FFFF);
    write_word(gpio_pkg::AddrClr1, 32'h0020_0001);
    write_word(gpio_pkg::AddrClr0, 32'hA5A5_A5A5);
  endtask

  // level words read the sampled pins, writes to them do nothing
  task automatic test_levels();
    read_word(gpio_pkg::AddrLev0, '1);
    read_word(gpio_pkg::AddrLev1, '1);
    write_word(gpio_pkg::AddrLev0, 32'hFFFF_FFFF);
  endtask

  // pull up, pull down, the reserved mode three and clearing back to off
  task automatic test_pull();
    write_word(gpio_pkg::AddrPullMode, 32'(gpio_pkg::PullUp));
    write_word(gpio_pkg::AddrPullClk0, 32'hFFFF_FFFF);
    write_word(gpio_pkg::AddrPullMode, 32'(gpio_pkg::PullDown));
    write_word(gpio_pkg::AddrPullClk1, 32'hFFFF_FFFF);
    write_word(gpio_pkg::AddrPullMode, 32'hFFFF_FFFF);
    write_word(gpio_pkg::AddrPullClk0, 32'h0000_000F);
    read_word(gpio_pkg::AddrPullMode, random_levels());
    write_word(gpio_pkg::AddrPullMode, 32'h0);
    write_word(gpio_pkg::AddrPullClk1, 32'h0000_0001);
  endtask

  // holes in the word map
  task automatic test_unmapped();
    write_word(AddrHole, 32'hFFFF_FFFF);
    read_word(AddrHole, '1);
    read_word(AddrTop, '1);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic
  // ---------------------------------------------------------------------------
  // select word data: either raw bits or codes biased toward output
  function automatic logic [gpio_pkg::DataW-1:0] random_fsel_data();
    logic [gpio_pkg::DataW-1:0] d;
    if ($urandom_range(1) == 0)
      return $urandom();
    d = $urandom();
    for (int k = 0; k < gpio_pkg::PinsPerWord; k++)
      if ($urandom_range(1) == 0)
        d[gpio_pkg::FselBits*k +: gpio_pkg::FselBits] = gpio_pkg::FuncOutput;
    return d;
  endfunction

  function automatic gpio_pkg::req_t random_access();
    gpio_pkg::req_t a;
    int             pick;
    a.command    = logic'($urandom_range(1));
    a.write_data = $urandom();
    a.pin_levels = random_levels();
    pick = $urandom_range(99);
    if (pick < 30) begin
      a.address = gpio_pkg::AddrW'($urandom_range(5));
      if (a.command == gpio_pkg::CmdWrite)
        a.write_data = random_fsel_data();
    end else if (pick < 50) begin
      case ($urandom_range(3))
        0:       a.address = gpio_pkg::AddrSet0;
        1:       a.address = gpio_pkg::AddrSet1;
        2:       a.address = gpio_pkg::AddrClr0;
        default: a.address = gpio_pkg::AddrClr1;
      endcase
      a.command = ($urandom_range(7) == 0) ? gpio_pkg::CmdRead : gpio_pkg::CmdWrite;
    end else if (pick < 62) begin
      a.address = ($urandom_range(1) == 0) ? gpio_pkg::AddrLev0 : gpio_pkg::AddrLev1;
    end else if (pick < 72) begin
      a.address = gpio_pkg::AddrPullMode;
    end else if (pick < 84) begin
      a.address = ($urandom_range(1) == 0) ? gpio_pkg::AddrPullClk0 : gpio_pkg::AddrPullClk1;
    end else begin
      // anywhere on the bus, mostly unmapped words
      a.address = gpio_pkg::AddrW'($urandom_range(63));
    end
    return a;
  endfunction

  // well-formed pull setup: pick a mode, then clock it into some pins
  task automatic send_pull_sequence();
    write_word(gpio_pkg::AddrPullMode, $urandom());
    write_word(($urandom_range(1) == 0) ? gpio_pkg::AddrPullClk0 : gpio_pkg::AddrPullClk1,
               $urandom());
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct);
    for (int n = 0; n < ItemsPerPhase; n++) begin
      while ($urandom_range(99) < idle_pct)
        idle_cycle();
      if ($urandom_range(99) < 12)
        send_pull_sequence();
      else
        send_access(random_access());
    end
    wait_replies();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_function_select();
    test_set_clear();
    test_levels();
    test_pull();
    test_unmapped();
    wait_replies();

    test_random_traffic(0);
    test_random_traffic(68);
    test_random_traffic(17);

    // no more items: let any trailing reply land
    idle_cycle();
    while (awaited_replies.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d accesses (%0d reads, %0d writes), %0d replies checked",
             items_accepted, reads_accepted, items_accepted - reads_accepted,
             replies_seen);
    $display("word map corners, pull modes and sender idle rates 0/17/68%%, %0d mismatches",
             mismatches);
    if (mismatches == 0 && awaited_replies.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
